// ===== src/otsp_pkg.sv =====
package otsp_pkg;

   // Fixed field widths.
   localparam int CHAR_W    = 8;
   localparam int SYM_W     = 3;
   localparam int VALUE_W   = 32;
   localparam int ACC_W     = 31;
   localparam int COUNT_W   = 5;
   localparam int DIGIT_W   = 4;

   // Defaults for the top-level parameters.
   localparam int PATTERN_MAX_DEFAULT = 31;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Characters of interest.
   localparam logic [CHAR_W-1:0] CHAR_M  = 8'h4D;
   localparam logic [CHAR_W-1:0] CHAR_N  = 8'h4E;
   localparam logic [CHAR_W-1:0] CHAR_W_ = 8'h57;
   localparam logic [CHAR_W-1:0] CHAR_S  = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_T  = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_0  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LF = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UF = 8'h46;

   // Pattern symbol codes.
   localparam logic [SYM_W-1:0] SYM_M   = 3'd0;
   localparam logic [SYM_W-1:0] SYM_N   = 3'd1;
   localparam logic [SYM_W-1:0] SYM_WIN = 3'd2;
   localparam logic [SYM_W-1:0] SYM_S   = 3'd3;
   localparam logic [SYM_W-1:0] SYM_T   = 3'd4;

   // Result kinds.
   localparam logic KIND_SYMBOL  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Saturation value and the "not seen" marker for MSS and window scale.
   localparam logic [ACC_W-1:0]   ACC_SAT    = {ACC_W{1'b1}};
   localparam logic [VALUE_W-1:0] VALUE_NONE = {VALUE_W{1'b1}};

   // Scanner mode, one-hot.
   typedef enum logic [3:0] {
      MODE_LETTER = 4'b0001,
      MODE_MSS    = 4'b0010,
      MODE_WIN    = 4'b0100,
      MODE_SKIP   = 4'b1000
   } mode_type;

   // One queued transaction record: an optional symbol result, an optional summary
   // result, and the values that both of them report.
   typedef struct packed {
      logic                has_sym;
      logic [SYM_W-1:0]    sym;
      logic                last;
      logic [VALUE_W-1:0]  mss;
      logic [VALUE_W-1:0]  wscale;
      logic                sack;
      logic                ts;
      logic [COUNT_W-1:0]  count;
   } entry_type;

endpackage

// ===== src/tcp_option_string_parser.sv =====
// TCP option pattern string parser.
// The req channel takes one character per transaction (req_ch) with req_final_char
// marking the last character of a string. The rsp channel returns one transaction per
// recognized pattern letter (M, N, W, S, T) and, after the last character, one
// summary transaction; a final character that is also a letter yields two.
// A character transaction is accepted every cycle while the record queue between the
// parser and the result stage has room; the parser state (mode, hex accumulator, MSS,
// window scale, flags, symbol count) updates in that same cycle.
// The first result of a character goes through the queue and then the output register:
// its accepting edge writes the queue, and the output register loads from the queue head.
// The result stage issues one result per cycle while the receiver is ready, so the
// sustained rate is one character per cycle, limited by the receiver and by the single
// output register when characters produce two results.
// When the receiver stalls, results wait in the output register and the queue keeps
// absorbing records; req_ready drops only once QUEUE_DEPTH records are waiting.
// Reset clears the parser to its start-of-string state (MSS and window scale -1),
// empties the queue and drops rsp_valid. The last character of a string also returns
// the parser to that state for the next string.
module tcp_option_string_parser
   import otsp_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [CHAR_W-1:0]         req_ch,
   input  logic                      req_final_char,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic [SYM_W-1:0]          rsp_symbol,
   output logic signed [VALUE_W-1:0] rsp_mss_value,
   output logic signed [VALUE_W-1:0] rsp_wscale_value,
   output logic                      rsp_sack_seen,
   output logic                      rsp_timestamp_seen,
   output logic [COUNT_W-1:0]        rsp_symbol_count,
   output logic                      rsp_run_end
);

   // Records between the parser and the result stage.
   logic      q_push;
   entry_type q_push_data;
   logic      q_full;
   logic      q_pop;
   logic      q_valid;
   entry_type q_head;

   // The parser classifies each character and updates the scan state at once.
   otsp_front #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_final_char (req_final_char),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_push_data    (q_push_data)
   );

   otsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   // The result stage expands each record into one or two result transactions.
   otsp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_symbol         (rsp_symbol),
      .rsp_mss_value      (rsp_mss_value),
      .rsp_wscale_value   (rsp_wscale_value),
      .rsp_sack_seen      (rsp_sack_seen),
      .rsp_timestamp_seen (rsp_timestamp_seen),
      .rsp_symbol_count   (rsp_symbol_count),
      .rsp_run_end        (rsp_run_end)
   );

   // A symbol result that does not end its run is always followed by that run's summary.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_SYMBOL) && !rsp_run_end
      |=> rsp_valid && (rsp_kind == KIND_SUMMARY))
      else $error("symbol result without run end not followed by summary");

   // An M symbol result reports a fresh MSS of zero, since its digits come later.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SYMBOL) && (rsp_symbol == SYM_M)
      |-> (rsp_mss_value == '0))
      else $error("M symbol result with nonzero MSS");

   // A symbol result always counts itself.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SYMBOL) |-> (rsp_symbol_count != '0))
      else $error("symbol result with zero symbol count");

   // Reset leaves no stale result on the output.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== src/otsp_front.sv =====
module otsp_front
   import otsp_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CHAR_W-1:0] req_ch,
   input  logic              req_final_char,
   input  logic              q_full,
   output logic              q_push,
   output entry_type         q_push_data
);

   mode_type             mode_ff, mode_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [VALUE_W-1:0]   mss_ff, mss_in;
   logic [VALUE_W-1:0]   wscale_ff, wscale_in;
   logic                 sack_ff, sack_in;
   logic                 ts_ff, ts_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 accept;
   logic                 hex_ok;
   logic [DIGIT_W-1:0]   hex_digit;
   logic                 used;
   logic                 has_sym;
   logic [SYM_W-1:0]     sym;
   logic [ACC_W-1:0]     acc_step;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hex_ok    = 1'b0;
      hex_digit = '0;
      if (req_ch >= CHAR_0 && req_ch <= CHAR_9) begin
         hex_ok    = 1'b1;
         hex_digit = DIGIT_W'(req_ch - CHAR_0);
      end else if (req_ch >= CHAR_LA && req_ch <= CHAR_LF) begin
         hex_ok    = 1'b1;
         hex_digit = DIGIT_W'(req_ch - CHAR_LA + 8'd10);
      end else if (req_ch >= CHAR_UA && req_ch <= CHAR_UF) begin
         hex_ok    = 1'b1;
         hex_digit = DIGIT_W'(req_ch - CHAR_UA + 8'd10);
      end
   end

   // Shifting in one more digit overflows exactly when any of the top four bits is set.
   assign acc_step = (acc_ff[ACC_W-1 -: DIGIT_W] != '0) ? ACC_SAT
                                                         : {acc_ff[ACC_W-DIGIT_W-1:0], hex_digit};

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      mss_in    = mss_ff;
      wscale_in = wscale_ff;
      sack_in   = sack_ff;
      ts_in     = ts_ff;
      count_in  = count_ff;
      has_sym   = 1'b0;
      sym       = SYM_M;
      used      = (mode_ff != MODE_LETTER) && hex_ok;

      if (used) begin
         if (mode_ff == MODE_MSS) begin
            acc_in = acc_step;
            mss_in = {1'b0, acc_step};
         end else if (mode_ff == MODE_WIN) begin
            acc_in    = acc_step;
            wscale_in = {1'b0, acc_step};
         end
      end else begin
         mode_in = MODE_LETTER;
      end

      if (!used && (count_ff < COUNT_W'(PATTERN_MAX))) begin
         case (req_ch)
            CHAR_M: begin
               has_sym = 1'b1;
               sym     = SYM_M;
               mss_in  = '0;
               acc_in  = '0;
               mode_in = MODE_MSS;
            end
            CHAR_N: begin
               has_sym = 1'b1;
               sym     = SYM_N;
            end
            CHAR_W_: begin
               has_sym   = 1'b1;
               sym       = SYM_WIN;
               wscale_in = '0;
               acc_in    = '0;
               mode_in   = MODE_WIN;
            end
            CHAR_S: begin
               has_sym = 1'b1;
               sym     = SYM_S;
               sack_in = 1'b1;
            end
            CHAR_T: begin
               has_sym = 1'b1;
               sym     = SYM_T;
               ts_in   = 1'b1;
               mode_in = MODE_SKIP;
            end
            default: begin
               has_sym = 1'b0;
            end
         endcase
      end

      if (has_sym) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   // Both results of one transaction report the same values.
   always_comb begin
      q_push_data.has_sym = has_sym;
      q_push_data.sym     = sym;
      q_push_data.last    = req_final_char;
      q_push_data.mss     = mss_in;
      q_push_data.wscale  = wscale_in;
      q_push_data.sack    = sack_in;
      q_push_data.ts      = ts_in;
      q_push_data.count   = count_in;
   end

   assign q_push = accept && (has_sym || req_final_char);

   always_ff @(posedge clock) begin
      if (reset || (accept && req_final_char)) begin
         mode_ff   <= MODE_LETTER;
         acc_ff    <= '0;
         mss_ff    <= VALUE_NONE;
         wscale_ff <= VALUE_NONE;
         sack_ff   <= 1'b0;
         ts_ff     <= 1'b0;
         count_ff  <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         mss_ff    <= mss_in;
         wscale_ff <= wscale_in;
         sack_ff   <= sack_in;
         ts_ff     <= ts_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/otsp_queue.sv =====
module otsp_queue
   import otsp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== src/otsp_back.sv =====
module otsp_back
   import otsp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  entry_type                 q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic [SYM_W-1:0]          rsp_symbol,
   output logic signed [VALUE_W-1:0] rsp_mss_value,
   output logic signed [VALUE_W-1:0] rsp_wscale_value,
   output logic                      rsp_sack_seen,
   output logic                      rsp_timestamp_seen,
   output logic [COUNT_W-1:0]        rsp_symbol_count,
   output logic                      rsp_run_end
);

   logic                 valid_ff;
   logic                 phase_ff;
   logic                 kind_ff;
   logic [SYM_W-1:0]     symbol_ff;
   logic [VALUE_W-1:0]   mss_ff;
   logic [VALUE_W-1:0]   wscale_ff;
   logic                 sack_ff;
   logic                 ts_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 run_end_ff;

   logic                 load;
   logic                 emit_sym;

   assign load     = !valid_ff || rsp_ready;
   // The symbol result goes first; a record with no symbol holds a summary only.
   assign emit_sym = q_data.has_sym && !phase_ff;
   assign q_pop    = load && q_valid && !(emit_sym && q_data.last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= q_valid;
         if (q_valid) begin
            phase_ff <= emit_sym && q_data.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && q_valid) begin
         kind_ff    <= emit_sym ? KIND_SYMBOL : KIND_SUMMARY;
         symbol_ff  <= emit_sym ? q_data.sym : SYM_M;
         run_end_ff <= emit_sym ? !q_data.last : 1'b1;
         mss_ff     <= q_data.mss;
         wscale_ff  <= q_data.wscale;
         sack_ff    <= q_data.sack;
         ts_ff      <= q_data.ts;
         count_ff   <= q_data.count;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_symbol         = symbol_ff;
   assign rsp_mss_value      = $signed(mss_ff);
   assign rsp_wscale_value   = $signed(wscale_ff);
   assign rsp_sack_seen      = sack_ff;
   assign rsp_timestamp_seen = ts_ff;
   assign rsp_symbol_count   = count_ff;
   assign rsp_run_end        = run_end_ff;

endmodule

// ===== tb/tb_tcp_option_string_parser.sv =====
module tb_tcp_option_string_parser;
   import otsp_pkg::*;

   // The run ends here even if the block stops answering.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_PERCENT = 34;

   // One result transaction as seen on the rsp channel.
   typedef struct {
      logic                kind;
      logic [SYM_W-1:0]    symbol;
      logic [VALUE_W-1:0]  mss;
      logic [VALUE_W-1:0]  wscale;
      logic                sack;
      logic                ts;
      logic [COUNT_W-1:0]  count;
      logic                run_end;
   } parse_result_type;

   // The scoreboard keeps its own copy of the parser state. Every accepted
   // character is run through it, and the results that character should cause
   // are queued in order. Each result that the block hands out is checked
   // against the oldest queued one.
   class pattern_scoreboard;
      mode_type            mode;
      logic [ACC_W-1:0]    hex_acc;
      logic [VALUE_W-1:0]  mss;
      logic [VALUE_W-1:0]  wscale;
      logic                sack;
      logic                ts;
      logic [COUNT_W-1:0]  count;
      parse_result_type    awaited_results[$];
      int                  errors;

      function new();
         errors = 0;
         restart_string();
      endfunction

      function void restart_string();
         mode    = MODE_LETTER;
         hex_acc = '0;
         mss     = VALUE_NONE;
         wscale  = VALUE_NONE;
         sack    = 1'b0;
         ts      = 1'b0;
         count   = '0;
      endfunction

      function parse_result_type snapshot(logic kind, logic [SYM_W-1:0] symbol);
         parse_result_type r;
         r.kind    = kind;
         r.symbol  = symbol;
         r.mss     = mss;
         r.wscale  = wscale;
         r.sack    = sack;
         r.ts      = ts;
         r.count   = count;
         r.run_end = 1'b1;
         return r;
      endfunction

      function void parse_char(logic [CHAR_W-1:0] ch, logic fin);
         int               digit;
         int unsigned      acc;
         bit               consumed;
         bit               have_symbol;
         logic [SYM_W-1:0] symbol;
         parse_result_type symbol_result;

         digit       = -1;
         consumed    = 1'b0;
         have_symbol = 1'b0;
         symbol      = SYM_M;
         if (ch >= CHAR_0 && ch <= CHAR_9) begin
            digit = ch - CHAR_0;
         end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
            digit = ch - CHAR_LA + 10;
         end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
            digit = ch - CHAR_UA + 10;
         end

         // A hex digit extends the number in progress, or is swallowed after T.
         // Anything else drops back to letter scanning and is handled below.
         if (mode != MODE_LETTER && digit >= 0) begin
            consumed = 1'b1;
            if (mode == MODE_MSS || mode == MODE_WIN) begin
               acc = hex_acc;
               if (acc > ((32'({1'b0, ACC_SAT}) - digit) >> 4)) begin
                  acc = 32'({1'b0, ACC_SAT});
               end else begin
                  acc = (acc << 4) + digit;
               end
               hex_acc = acc[ACC_W-1:0];
               if (mode == MODE_MSS) begin
                  mss = {1'b0, hex_acc};
               end else begin
                  wscale = {1'b0, hex_acc};
               end
            end
         end else begin
            mode = MODE_LETTER;
         end

         // Letters only count while the pattern still has room.
         if (!consumed && count < PATTERN_MAX_DEFAULT) begin
            have_symbol = 1'b1;
            case (ch)
               CHAR_M: begin
                  symbol  = SYM_M;
                  mss     = '0;
                  hex_acc = '0;
                  mode    = MODE_MSS;
               end
               CHAR_N: begin
                  symbol = SYM_N;
               end
               CHAR_W_: begin
                  symbol  = SYM_WIN;
                  wscale  = '0;
                  hex_acc = '0;
                  mode    = MODE_WIN;
               end
               CHAR_S: begin
                  symbol = SYM_S;
                  sack   = 1'b1;
               end
               CHAR_T: begin
                  symbol = SYM_T;
                  ts     = 1'b1;
                  mode   = MODE_SKIP;
               end
               default: begin
                  have_symbol = 1'b0;
               end
            endcase
            if (have_symbol) begin
               count = count + 1'b1;
               symbol_result = snapshot(KIND_SYMBOL, symbol);
            end
         end

         // On the last character the summary becomes the final result, so a
         // symbol result in front of it no longer ends the run.
         if (have_symbol) begin
            symbol_result.run_end = !fin;
            awaited_results.push_back(symbol_result);
         end
         if (fin) begin
            awaited_results.push_back(snapshot(KIND_SUMMARY, SYM_M));
            restart_string();
         end
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $error("field %s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type want;
         if (awaited_results.size() == 0) begin
            $error("result transaction with nothing outstanding: kind %0d symbol %0d",
                   got.kind, got.symbol);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("symbol", want.symbol, got.symbol);
         compare_field("mss_value", $signed(want.mss), $signed(got.mss));
         compare_field("wscale_value", $signed(want.wscale), $signed(got.wscale));
         compare_field("sack_seen", want.sack, got.sack);
         compare_field("timestamp_seen", want.ts, got.ts);
         compare_field("symbol_count", want.count, got.count);
         compare_field("run_end", want.run_end, got.run_end);
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [CHAR_W-1:0]         req_ch;
   logic                      req_final_char;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_kind;
   logic [SYM_W-1:0]          rsp_symbol;
   logic signed [VALUE_W-1:0] rsp_mss_value;
   logic signed [VALUE_W-1:0] rsp_wscale_value;
   logic                      rsp_sack_seen;
   logic                      rsp_timestamp_seen;
   logic [COUNT_W-1:0]        rsp_symbol_count;
   logic                      rsp_run_end;

   pattern_scoreboard sb = new();

   // While this is set neither side idles, so back-to-back transactions on
   // both channels get a long run of their own.
   bit steady_flow = 1'b0;
   int chars_sent  = 0;
   int cycle_count = 0;

   logic [CHAR_W-1:0] pattern_letters [5] = '{CHAR_M, CHAR_N, CHAR_W_, CHAR_S, CHAR_T};

   tcp_option_string_parser u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ch             (req_ch),
      .req_final_char     (req_final_char),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_symbol         (rsp_symbol),
      .rsp_mss_value      (rsp_mss_value),
      .rsp_wscale_value   (rsp_wscale_value),
      .rsp_sack_seen      (rsp_sack_seen),
      .rsp_timestamp_seen (rsp_timestamp_seen),
      .rsp_symbol_count   (rsp_symbol_count),
      .rsp_run_end        (rsp_run_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offers one character and returns once the block has taken it. Random idle
   // cycles go in front of the transaction. Valid is only ever assigned once
   // per edge, so a character that follows directly keeps valid high.
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic fin);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_ch         <= ch;
      req_final_char <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.parse_char(ch, fin);
      chars_sent++;
   endtask

   function automatic logic [CHAR_W-1:0] random_hex_char();
      int pick;
      pick = $urandom_range(0, 21);
      if (pick < 10) return CHAR_W'(CHAR_0 + pick);
      if (pick < 16) return CHAR_W'(CHAR_LA + (pick - 10));
      return CHAR_W'(CHAR_UA + (pick - 16));
   endfunction

   // Builds one option string and sends it. Most strings are proper patterns:
   // letters followed by a few hex digits, now and then a long number that
   // saturates, and now and then more letters than the pattern can hold.
   // The rest are plain noise or patterns with stray characters mixed in.
   task automatic send_random_string();
      logic [CHAR_W-1:0] text[$];
      int shape;
      int tokens;
      int digits;
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         repeat ($urandom_range(1, 6)) text.push_back(CHAR_W'($urandom_range(1, 255)));
      end else begin
         tokens = (shape < 18) ? $urandom_range(30, 40) : $urandom_range(1, 8);
         if (shape >= 92) begin
            // Digits with no letter in front of them are ignored.
            repeat ($urandom_range(1, 3)) text.push_back(random_hex_char());
         end
         repeat (tokens) begin
            text.push_back(pattern_letters[$urandom_range(0, 4)]);
            digits = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10)
                                                 : $urandom_range(0, 3);
            repeat (digits) text.push_back(random_hex_char());
            if ($urandom_range(0, 7) == 0 || (shape >= 92 && $urandom_range(0, 2) == 0)) begin
               text.push_back(CHAR_W'($urandom_range(1, 255)));
            end
         end
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   // Result side: checks every accepted transaction and then decides whether
   // to stall on the next edge.
   initial begin
      parse_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.kind    = rsp_kind;
            got.symbol  = rsp_symbol;
            got.mss     = rsp_mss_value;
            got.wscale  = rsp_wscale_value;
            got.sack    = rsp_sack_seen;
            got.ts      = rsp_timestamp_seen;
            got.count   = rsp_symbol_count;
            got.run_end = rsp_run_end;
            sb.check_result(got);
         end
         rsp_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int string_index;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_ch         <= 8'h01;
      req_final_char <= 1'b0;
      rsp_ready      <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Extreme character codes, a digit in letter mode, an MSS
      // built from digits of all three kinds, a letter that ends a number, a
      // window scale that saturates, a final character that is also a letter,
      // digits skipped after T, an M with no digits, and a final character
      // that is ignored.
      send_char(8'h01, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CHAR_N, 1'b0);
      send_char("0", 1'b0);
      send_char(CHAR_M, 1'b0);
      send_char("1", 1'b0);
      send_char("a", 1'b0);
      send_char("F", 1'b0);
      send_char(CHAR_W_, 1'b0);
      repeat (8) send_char("F", 1'b0);
      send_char(CHAR_T, 1'b1);
      send_char(CHAR_T, 1'b0);
      send_char("c", 1'b0);
      send_char(CHAR_S, 1'b0);
      send_char(CHAR_M, 1'b1);
      send_char(CHAR_W_, 1'b0);
      send_char("9", 1'b0);
      send_char(8'hFF, 1'b1);

      // Random part. Once early on, and at random later, the sender holds off
      // until every outstanding result has come back.
      string_index = 0;
      while (chars_sent < RANDOM_ITEMS) begin
         steady_flow = (chars_sent >= 600 && chars_sent < 900);
         send_random_string();
         if (string_index == 3 || $urandom_range(0, 14) == 0) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.outstanding() != 0);
         end
         string_index++;
      end
      steady_flow = 1'b0;

      // Drain, then keep the clock running so that any stray result shows.
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/otsp_pkg.sv
src/otsp_front.sv
src/otsp_queue.sv
src/otsp_back.sv
src/tcp_option_string_parser.sv
tb/tb_tcp_option_string_parser.sv
